// ===== rtl/core/quad_corner_plausibility_check_assert.svh =====
// assertion macros shared by the quad plausibility check rtl
// expects a clock named clk and a synchronous active-high reset named rst in scope
`ifndef QUAD_CORNER_PLAUSIBILITY_CHECK_ASSERT_SVH
`define QUAD_CORNER_PLAUSIBILITY_CHECK_ASSERT_SVH

// checked outside reset
`define QCPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define QCPC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/qcpc_pkg.sv =====
// types, widths and constants of the quad corner plausibility check
// used by qcpc_angle and quad_corner_plausibility_check
`timescale 1ns / 1ps

package qcpc_pkg;

  localparam int FRAC_BITS = 4;
  localparam int ONE       = 1 << FRAC_BITS;

  // coordinate and derived widths
  localparam int CW    = 20;            // corner coordinate
  localparam int EW    = CW + 1;        // edge vector component
  localparam int SQW   = 2 * EW - 2;    // square of an edge component
  localparam int SDW   = SQW + 1;       // squared side length
  localparam int DTW   = 2 * EW;        // dot product, signed
  localparam int OPW   = 22;            // half operand of the angle products
  localparam int MW    = 2 * OPW;       // angle product operand
  localparam int PW    = 2 * MW;        // angle product
  localparam int RW    = SDW + 6;       // 49 times the shortest side
  localparam int CMP_W = CW + FRAC_BITS + 14;

  // configuration
  localparam int DIM_W   = 12;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(1);
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = DIM_W'(480);
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = DIM_W'(640);

  // check constants
  localparam int MARGIN_X = 30;
  localparam int MARGIN_Y = 20;
  localparam logic signed [EW-1:0]    GAP = EW'(5 * ONE);
  localparam logic signed [CMP_W-1:0] XLO = CMP_W'(-(MARGIN_X * ONE));
  localparam logic signed [CMP_W-1:0] YLO = CMP_W'(-(MARGIN_Y * ONE));
  localparam logic [SDW-1:0] MIN_SIDE_SQ = SDW'(400) << (2 * FRAC_BITS);

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [EW-1:0]  edge_t;
  typedef logic [SDW-1:0]        side_t;
  typedef logic signed [DTW-1:0] dot_t;

  typedef enum logic [2:0] {
    RSN_PASS    = 3'd0,
    RSN_ORDER   = 3'd1,
    RSN_OUTSIDE = 3'd2,
    RSN_SHORT   = 3'd3,
    RSN_RATIO   = 3'd4,
    RSN_SHARP   = 3'd5
  } qcpc_reason_t;

  // load enables of the angle stages
  typedef struct packed {
    logic s4;
    logic s5;
    logic s6;
  } qcpc_adv_t;

endpackage

// ===== rtl/core/quad_corner_plausibility_check.sv =====
// Quad corner plausibility check, top level.
// Input channel: in_valid/in_ready carry the four corners (corner0..3, x and y,
// 20-bit signed, 4 fraction bits). Output channel: out_valid/out_ready carry
// quad_ok and fail_reason (0 pass, 1 order, 2 all outside, 3 short side,
// 4 side ratio, 5 sharp angle; the first failing check wins).
// Configuration: cfg_wen writes cfg_data into register cfg_index
// (0 image_height, 1 image_width) at the clock edge; write only while idle.
// Pipeline: eight register stages (0 to 7); the result is registered in stage 7.
// Throughput: one item per cycle while out_ready lets the output move on, since every
// stage can then load; the 21x21 and 22x22 multiplier stages each end at a register.
// Each stage holds its item while the one after it is full and stalled, so
// bubbles close up and a stalled receiver only blocks the input once every
// stage is occupied.
// Reset (rst, synchronous) empties the pipeline and loads 480 x 640.
// Depends on qcpc_pkg and qcpc_angle.
`timescale 1ns / 1ps

`include "quad_corner_plausibility_check_assert.svh"

module quad_corner_plausibility_check (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wen,
  input  logic [qcpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qcpc_pkg::DIM_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [qcpc_pkg::CW-1:0]      corner0_x,
  input  logic signed [qcpc_pkg::CW-1:0]      corner0_y,
  input  logic signed [qcpc_pkg::CW-1:0]      corner1_x,
  input  logic signed [qcpc_pkg::CW-1:0]      corner1_y,
  input  logic signed [qcpc_pkg::CW-1:0]      corner2_x,
  input  logic signed [qcpc_pkg::CW-1:0]      corner2_y,
  input  logic signed [qcpc_pkg::CW-1:0]      corner3_x,
  input  logic signed [qcpc_pkg::CW-1:0]      corner3_y,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                quad_ok,
  output logic [2:0]                          fail_reason
);

  localparam int NSTG  = 8;
  localparam int EW    = qcpc_pkg::EW;
  localparam int SQW   = qcpc_pkg::SQW;
  localparam int SDW   = qcpc_pkg::SDW;
  localparam int DTW   = qcpc_pkg::DTW;
  localparam int RW    = qcpc_pkg::RW;
  localparam int CMP_W = qcpc_pkg::CMP_W;
  localparam int DIM_W = qcpc_pkg::DIM_W;

  logic [DIM_W-1:0] image_height, image_width;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  // stage 0: captured corners
  qcpc_pkg::coord_t cx0 [4];
  qcpc_pkg::coord_t cy0 [4];

  // stage 1
  logic             ord1, out1;
  qcpc_pkg::edge_t  ex1 [4];
  qcpc_pkg::edge_t  ey1 [4];
  logic             ord_fail, out_fail;
  logic [3:0]       corner_out;
  logic signed [CMP_W-1:0] xhi, yhi;

  // stage 2
  logic             ord2, out2;
  logic [SQW-1:0]   sqx2 [4];
  logic [SQW-1:0]   sqy2 [4];
  qcpc_pkg::dot_t   cpx2 [4];
  qcpc_pkg::dot_t   cpy2 [4];

  // stage 3
  logic             ord3, out3;
  qcpc_pkg::side_t  side3 [4];
  qcpc_pkg::dot_t   dot3 [4];

  // stage 4
  logic             ord4, out4, short4;
  qcpc_pkg::side_t  max01, min01, max23, min23;

  // stage 5
  logic             ord5, out5, short5;
  qcpc_pkg::side_t  mx5, mn5;

  // stage 6
  logic             ord6, out6, short6, ratio6;
  logic [3:0]       sharp6;
  logic [RW-1:0]    ratio_lim;

  // stage 7: output
  qcpc_pkg::qcpc_reason_t reason, reason_next;
  qcpc_pkg::qcpc_adv_t    ang_adv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height <= qcpc_pkg::IMAGE_HEIGHT_RST;
      image_width  <= qcpc_pkg::IMAGE_WIDTH_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        qcpc_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        qcpc_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or the stage after it moves on
  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // stage 0
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      cx0[0] <= corner0_x;  cy0[0] <= corner0_y;
      cx0[1] <= corner1_x;  cy0[1] <= corner1_y;
      cx0[2] <= corner2_x;  cy0[2] <= corner2_y;
      cx0[3] <= corner3_x;  cy0[3] <= corner3_y;
    end
  end

  // stage 1: order and outside tests, edge vectors
  always_comb begin
    xhi = CMP_W'({1'b0, image_width} + (DIM_W + 1)'(qcpc_pkg::MARGIN_X))
          << qcpc_pkg::FRAC_BITS;
    yhi = CMP_W'({1'b0, image_height} + (DIM_W + 1)'(qcpc_pkg::MARGIN_Y))
          << qcpc_pkg::FRAC_BITS;
    ord_fail = (EW'(cy0[0]) + qcpc_pkg::GAP >= EW'(cy0[3])) ||
               (EW'(cy0[1]) + qcpc_pkg::GAP >= EW'(cy0[2])) ||
               (EW'(cx0[0]) + qcpc_pkg::GAP >= EW'(cx0[1])) ||
               (EW'(cx0[3]) + qcpc_pkg::GAP >= EW'(cx0[2]));
    for (int i = 0; i < 4; i++) begin
      corner_out[i] = (CMP_W'(cx0[i]) < qcpc_pkg::XLO) || (CMP_W'(cx0[i]) > xhi) ||
                      (CMP_W'(cy0[i]) < qcpc_pkg::YLO) || (CMP_W'(cy0[i]) > yhi);
    end
    out_fail = &corner_out;
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ord1 <= ord_fail;
      out1 <= out_fail;
      for (int i = 0; i < 4; i++) begin
        ex1[i] <= EW'(cx0[2'(i + 1)]) - EW'(cx0[i]);
        ey1[i] <= EW'(cy0[2'(i + 1)]) - EW'(cy0[i]);
      end
    end
  end

  // stage 2: squares of edges, products of adjacent edges
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      ord2 <= ord1;
      out2 <= out1;
      for (int i = 0; i < 4; i++) begin
        sqx2[i] <= SQW'(ex1[i] * ex1[i]);
        sqy2[i] <= SQW'(ey1[i] * ey1[i]);
        cpx2[i] <= DTW'(ex1[2'(i + 3)] * ex1[i]);
        cpy2[i] <= DTW'(ey1[2'(i + 3)] * ey1[i]);
      end
    end
  end

  // stage 3: side lengths and vertex dot products (arms point away from vertex)
  always_ff @(posedge clk) begin
    if (adv[3]) begin
      ord3 <= ord2;
      out3 <= out2;
      for (int i = 0; i < 4; i++) begin
        side3[i] <= SDW'(sqx2[i]) + SDW'(sqy2[i]);
        dot3[i]  <= -(cpx2[i] + cpy2[i]);
      end
    end
  end

  // stage 4: short side, first level of min / max
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      ord4   <= ord3;
      out4   <= out3;
      short4 <= (side3[0] < qcpc_pkg::MIN_SIDE_SQ) || (side3[1] < qcpc_pkg::MIN_SIDE_SQ) ||
                (side3[2] < qcpc_pkg::MIN_SIDE_SQ) || (side3[3] < qcpc_pkg::MIN_SIDE_SQ);
      max01  <= (side3[1] > side3[0]) ? side3[1] : side3[0];
      min01  <= (side3[1] < side3[0]) ? side3[1] : side3[0];
      max23  <= (side3[3] > side3[2]) ? side3[3] : side3[2];
      min23  <= (side3[3] < side3[2]) ? side3[3] : side3[2];
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ord5   <= ord4;
      out5   <= out4;
      short5 <= short4;
      mx5    <= (max23 > max01) ? max23 : max01;
      mn5    <= (min23 < min01) ? min23 : min01;
    end
  end

  // stage 6: longest side against 49 times the shortest (squared lengths)
  assign ratio_lim = (RW'(mn5) << 5) + (RW'(mn5) << 4) + RW'(mn5);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      ord6   <= ord5;
      out6   <= out5;
      short6 <= short5;
      ratio6 <= RW'(mx5) > ratio_lim;
    end
  end

  // angle units, vertex v between sides v-1 and v
  assign ang_adv.s4 = adv[4];
  assign ang_adv.s5 = adv[5];
  assign ang_adv.s6 = adv[6];

  for (genvar v = 0; v < 4; v++) begin : g_vertex
    qcpc_angle u_angle (
      .clk   (clk),
      .adv   (ang_adv),
      .len_a (side3[(v + 3) % 4]),
      .len_b (side3[v]),
      .dot   (dot3[v]),
      .sharp (sharp6[v])
    );
  end

  // stage 7: first failing check
  always_comb begin
    if (ord6)            reason_next = qcpc_pkg::RSN_ORDER;
    else if (out6)       reason_next = qcpc_pkg::RSN_OUTSIDE;
    else if (short6)     reason_next = qcpc_pkg::RSN_SHORT;
    else if (ratio6)     reason_next = qcpc_pkg::RSN_RATIO;
    else if (|sharp6)    reason_next = qcpc_pkg::RSN_SHARP;
    else                 reason_next = qcpc_pkg::RSN_PASS;
  end

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      reason <= reason_next;
    end
  end

  assign out_valid   = vld[NSTG-1];
  assign fail_reason = reason;
  assign quad_ok     = (reason == qcpc_pkg::RSN_PASS);

  `QCPC_ASSERT(a_ok_matches_reason,
    out_valid |-> (quad_ok == (fail_reason == 3'(qcpc_pkg::RSN_PASS))),
    "quad_ok disagrees with fail_reason")
  `QCPC_ASSERT(a_empty_out_ready,
    !out_valid |-> in_ready,
    "input blocked with an empty output register")
  `QCPC_ASSERT(a_block_only_when_full,
    !in_ready |-> (out_valid && !out_ready && (&vld)),
    "input blocked while a stage is free")
  `QCPC_ASSERT_ALWAYS(a_reset_empties,
    $past(rst) |-> !out_valid,
    "result presented right after reset")

endmodule

// ===== rtl/core/qcpc_angle.sv =====
// sharp angle test for one vertex: 4*dot^2 > 3*|a|^2*|b|^2 with dot > 0
// three register stages; depends on qcpc_pkg
`timescale 1ns / 1ps

module qcpc_angle (
  input  logic                    clk,
  input  qcpc_pkg::qcpc_adv_t     adv,
  input  qcpc_pkg::side_t         len_a,
  input  qcpc_pkg::side_t         len_b,
  input  qcpc_pkg::dot_t          dot,
  output logic                    sharp
);

  localparam int OPW = qcpc_pkg::OPW;
  localparam int MW  = qcpc_pkg::MW;
  localparam int PW  = qcpc_pkg::PW;
  localparam int SDW = qcpc_pkg::SDW;

  logic          dpos4, dpos5, dpos6;
  logic [MW-1:0] lhs_a, lhs_b, rhs_a, rhs_b;
  logic [MW-1:0] lp_hh, lp_hl, lp_lh, lp_ll;
  logic [MW-1:0] rp_hh, rp_hl, rp_lh, rp_ll;
  logic [PW-1:0] lhs_prod, rhs_prod;

  // stage 4: operands, lhs = (4*dot) * dot, rhs = (3*len_a) * len_b
  always_ff @(posedge clk) begin
    if (adv.s4) begin
      dpos4 <= !dot[qcpc_pkg::DTW-1] && (dot != '0);
      lhs_a <= MW'({dot[SDW-1:0], 2'b00});
      lhs_b <= MW'(dot[SDW-1:0]);
      rhs_a <= MW'(len_a) + (MW'(len_a) << 1);
      rhs_b <= MW'(len_b);
    end
  end

  // stage 5: partial products on half-width operands
  always_ff @(posedge clk) begin
    if (adv.s5) begin
      dpos5 <= dpos4;
      lp_hh <= lhs_a[MW-1:OPW] * lhs_b[MW-1:OPW];
      lp_hl <= lhs_a[MW-1:OPW] * lhs_b[OPW-1:0];
      lp_lh <= lhs_a[OPW-1:0]  * lhs_b[MW-1:OPW];
      lp_ll <= lhs_a[OPW-1:0]  * lhs_b[OPW-1:0];
      rp_hh <= rhs_a[MW-1:OPW] * rhs_b[MW-1:OPW];
      rp_hl <= rhs_a[MW-1:OPW] * rhs_b[OPW-1:0];
      rp_lh <= rhs_a[OPW-1:0]  * rhs_b[MW-1:OPW];
      rp_ll <= rhs_a[OPW-1:0]  * rhs_b[OPW-1:0];
    end
  end

  // stage 6: recombine
  always_ff @(posedge clk) begin
    if (adv.s6) begin
      dpos6    <= dpos5;
      lhs_prod <= (PW'(lp_hh) << MW) + ((PW'(lp_hl) + PW'(lp_lh)) << OPW) + PW'(lp_ll);
      rhs_prod <= (PW'(rp_hh) << MW) + ((PW'(rp_hl) + PW'(rp_lh)) << OPW) + PW'(rp_ll);
    end
  end

  assign sharp = dpos6 && (lhs_prod > rhs_prod);

endmodule

// ===== tb/sv/quad_corner_plausibility_check_tb.sv =====
// self-checking testbench for quad_corner_plausibility_check: directed corner cases,
// then random quads under several image sizes, checked against a scoreboard predictor
// depends on qcpc_pkg and the quad_corner_plausibility_check rtl
`timescale 1ns / 1ps

module quad_corner_plausibility_check_tb;

  localparam int PIPE_DEPTH = 8;
  localparam int ITEMS_PER_PHASE = 130;

  typedef struct {
    qcpc_pkg::coord_t x[4];
    qcpc_pkg::coord_t y[4];
  } quad_t;

  typedef struct packed {
    logic                   ok;
    qcpc_pkg::qcpc_reason_t reason;
  } verdict_t;

  class verdict_scoreboard;
    int       img_h;
    int       img_w;
    int       n_errors;
    verdict_t pending_verdicts[$];

    function new();
      img_h    = int'(qcpc_pkg::IMAGE_HEIGHT_RST);
      img_w    = int'(qcpc_pkg::IMAGE_WIDTH_RST);
      n_errors = 0;
    endfunction

    function void set_reg(logic [qcpc_pkg::CFG_IDX_W-1:0] idx,
                          logic [qcpc_pkg::DIM_W-1:0] data);
      if (idx == qcpc_pkg::REG_IMAGE_HEIGHT) begin
        img_h = int'(data);
      end else if (idx == qcpc_pkg::REG_IMAGE_WIDTH) begin
        img_w = int'(data);
      end
    endfunction

    function int pending_count();
      return pending_verdicts.size();
    endfunction

    // cosine above sqrt(3)/2, compared on squares at full width
    function bit arm_too_sharp(longint ax, longint ay, longint bx, longint by);
      longint     dot;
      logic [127:0] d, la, lb;
      dot = ax * bx + ay * by;
      if (dot <= 0) return 1'b0;
      d  = 128'(dot);
      la = 128'(ax * ax + ay * ay);
      lb = 128'(bx * bx + by * by);
      return (4 * d * d) > (3 * la * lb);
    endfunction

    function qcpc_pkg::qcpc_reason_t judge_quad(quad_t q);
      longint x[4], y[4], side[4];
      longint gap, xlo, xhi, ylo, yhi, mx, mn, minsq, dx, dy;
      int     outside;
      gap = 5 * qcpc_pkg::ONE;
      xlo = -qcpc_pkg::MARGIN_X * qcpc_pkg::ONE;
      ylo = -qcpc_pkg::MARGIN_Y * qcpc_pkg::ONE;
      xhi = (longint'(img_w) + qcpc_pkg::MARGIN_X) * qcpc_pkg::ONE;
      yhi = (longint'(img_h) + qcpc_pkg::MARGIN_Y) * qcpc_pkg::ONE;
      for (int i = 0; i < 4; i++) begin
        x[i] = q.x[i];
        y[i] = q.y[i];
      end
      if (y[0] + gap >= y[3] || y[1] + gap >= y[2]) return qcpc_pkg::RSN_ORDER;
      if (x[0] + gap >= x[1] || x[3] + gap >= x[2]) return qcpc_pkg::RSN_ORDER;
      outside = 0;
      for (int i = 0; i < 4; i++) begin
        if (x[i] < xlo || x[i] > xhi || y[i] < ylo || y[i] > yhi) outside++;
      end
      if (outside == 4) return qcpc_pkg::RSN_OUTSIDE;
      minsq = longint'(400) << (2 * qcpc_pkg::FRAC_BITS);
      for (int i = 0; i < 4; i++) begin
        dx      = x[i] - x[(i + 1) % 4];
        dy      = y[i] - y[(i + 1) % 4];
        side[i] = dx * dx + dy * dy;
        if (side[i] < minsq) return qcpc_pkg::RSN_SHORT;
      end
      mx = side[0];
      mn = side[0];
      for (int i = 1; i < 4; i++) begin
        if (side[i] > mx) mx = side[i];
        if (side[i] < mn) mn = side[i];
      end
      if (mx > 49 * mn) return qcpc_pkg::RSN_RATIO;
      if (arm_too_sharp(x[0] - x[1], y[0] - y[1], x[2] - x[1], y[2] - y[1]) ||
          arm_too_sharp(x[1] - x[2], y[1] - y[2], x[3] - x[2], y[3] - y[2]) ||
          arm_too_sharp(x[2] - x[3], y[2] - y[3], x[0] - x[3], y[0] - y[3]) ||
          arm_too_sharp(x[3] - x[0], y[3] - y[0], x[1] - x[0], y[1] - y[0]))
        return qcpc_pkg::RSN_SHARP;
      return qcpc_pkg::RSN_PASS;
    endfunction

    function void note_quad(quad_t q);
      verdict_t v;
      v.reason = judge_quad(q);
      v.ok     = (v.reason == qcpc_pkg::RSN_PASS);
      pending_verdicts.push_back(v);
    endfunction

    task report_mismatch(string what);
      n_errors++;
      if (n_errors <= 200) $display("%0t mismatch: %s", $time, what);
    endtask

    task check_verdict(logic ok, logic [2:0] reason);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("result ok=%0d reason=%0d with nothing pending", ok, reason));
        return;
      end
      v = pending_verdicts.pop_front();
      if (ok !== v.ok)
        report_mismatch($sformatf("quad_ok %0d, predicted %0d", ok, v.ok));
      if (reason !== v.reason)
        report_mismatch($sformatf("fail_reason %0d, predicted %0d", reason, v.reason));
    endtask
  endclass

  logic                           clk;
  logic                           rst;
  logic                           cfg_wen;
  logic [qcpc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [qcpc_pkg::DIM_W-1:0]     cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  qcpc_pkg::coord_t               corner0_x, corner0_y, corner1_x, corner1_y;
  qcpc_pkg::coord_t               corner2_x, corner2_y, corner3_x, corner3_y;
  logic                           out_valid;
  logic                           out_ready;
  logic                           quad_ok;
  logic [2:0]                     fail_reason;

  verdict_scoreboard sb = new();
  bit                steady = 1'b0;

  quad_corner_plausibility_check i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .corner0_x   (corner0_x),
    .corner0_y   (corner0_y),
    .corner1_x   (corner1_x),
    .corner1_y   (corner1_y),
    .corner2_x   (corner2_x),
    .corner2_y   (corner2_y),
    .corner3_x   (corner3_x),
    .corner3_y   (corner3_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .quad_ok     (quad_ok),
    .fail_reason (fail_reason)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

  // receiver side
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 37);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_verdict(quad_ok, fail_reason);
  end

  function automatic qcpc_pkg::coord_t clamp20(longint v);
    if (v > 524287) return qcpc_pkg::coord_t'(524287);
    if (v < -524288) return qcpc_pkg::coord_t'(-524288);
    return qcpc_pkg::coord_t'(v);
  endfunction

  function automatic longint span(longint lo, longint hi);
    return lo + longint'($urandom_range(32'(hi - lo), 0));
  endfunction

  function automatic quad_t mk(longint x0, longint y0, longint x1, longint y1,
                               longint x2, longint y2, longint x3, longint y3);
    quad_t q;
    q.x[0] = clamp20(x0); q.y[0] = clamp20(y0);
    q.x[1] = clamp20(x1); q.y[1] = clamp20(y1);
    q.x[2] = clamp20(x2); q.y[2] = clamp20(y2);
    q.x[3] = clamp20(x3); q.y[3] = clamp20(y3);
    return q;
  endfunction

  // mostly small quads, a few huge ones
  function automatic longint pick_half();
    int sel;
    sel = $urandom_range(9);
    if (sel < 3) return span(100, 400);
    if (sel < 7) return span(160, 1600);
    if (sel < 9) return span(1600, 16000);
    return span(16000, 200000);
  endfunction

  function automatic quad_t random_quad();
    quad_t  q;
    longint cx, cy, hw, hh, skew, jit, g;
    longint vx[4], vy[4];
    int     pick, k;
    pick = $urandom_range(99);
    if (pick < 10) begin
      // raw noise, every bit of every field
      for (k = 0; k < 4; k++) begin
        q.x[k] = qcpc_pkg::coord_t'($urandom);
        q.y[k] = qcpc_pkg::coord_t'($urandom);
      end
      return q;
    end
    hw = pick_half();
    hh = pick_half();
    if ($urandom_range(3) == 0) hh = hw;
    cx = span(-qcpc_pkg::MARGIN_X * qcpc_pkg::ONE,
              (longint'(sb.img_w) + qcpc_pkg::MARGIN_X) * qcpc_pkg::ONE);
    cy = span(-qcpc_pkg::MARGIN_Y * qcpc_pkg::ONE,
              (longint'(sb.img_h) + qcpc_pkg::MARGIN_Y) * qcpc_pkg::ONE);
    // far away from the image
    if (pick < 20) cx += ($urandom_range(1) ? 1 : -1) * span(80000, 300000);
    skew = ($urandom_range(3) == 0) ? span(-2 * hh, 2 * hh) : 0;
    case ($urandom_range(3))
      0:       jit = 0;
      1:       jit = 16;
      2:       jit = 160;
      default: jit = hw / 2;
    endcase
    vx[0] = cx - hw + skew; vy[0] = cy - hh;
    vx[1] = cx + hw + skew; vy[1] = cy - hh;
    vx[2] = cx + hw;        vy[2] = cy + hh;
    vx[3] = cx - hw;        vy[3] = cy + hh;
    for (k = 0; k < 4; k++) begin
      vx[k] += span(-jit, jit);
      vy[k] += span(-jit, jit);
    end
    if (pick >= 20 && pick < 30) begin
      // order gap right at the margin
      g = 5 * qcpc_pkg::ONE + span(-1, 1);
      case ($urandom_range(3))
        0:       vy[3] = vy[0] + g;
        1:       vy[2] = vy[1] + g;
        2:       vx[1] = vx[0] + g;
        default: vx[2] = vx[3] + g;
      endcase
    end else if (pick >= 30 && pick < 38) begin
      // one corner on or just past a box edge
      k = $urandom_range(3);
      case ($urandom_range(3))
        0:       vx[k] = -qcpc_pkg::MARGIN_X * qcpc_pkg::ONE - span(0, 1);
        1:       vx[k] = (longint'(sb.img_w) + qcpc_pkg::MARGIN_X) * qcpc_pkg::ONE
                         + span(0, 1);
        2:       vy[k] = -qcpc_pkg::MARGIN_Y * qcpc_pkg::ONE - span(0, 1);
        default: vy[k] = (longint'(sb.img_h) + qcpc_pkg::MARGIN_Y) * qcpc_pkg::ONE
                         + span(0, 1);
      endcase
    end
    for (k = 0; k < 4; k++) begin
      q.x[k] = clamp20(vx[k]);
      q.y[k] = clamp20(vy[k]);
    end
    return q;
  endfunction

  task automatic send_quad(quad_t q);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    corner0_x <= q.x[0]; corner0_y <= q.y[0];
    corner1_x <= q.x[1]; corner1_y <= q.y[1];
    corner2_x <= q.x[2]; corner2_y <= q.y[2];
    corner3_x <= q.x[3]; corner3_y <= q.y[3];
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_quad(q);
  endtask

  task automatic write_reg(logic [qcpc_pkg::CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= qcpc_pkg::DIM_W'(value);
    @(negedge clk);
    cfg_wen   <= 1'b0;
    sb.set_reg(idx, qcpc_pkg::DIM_W'(value));
  endtask

  // drop valid and wait until the pipeline has drained
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  task automatic run_directed();
    send_quad(mk(1600, 1600, 3200, 1600, 3200, 3200, 1600, 3200));
    // order gaps of exactly five on each relation, just above on the first, then swapped x0 and x1
    send_quad(mk(1600, 1600, 3200, 1600, 3200, 3200, 1600, 1680));
    send_quad(mk(1600, 1600, 3200, 1600, 3200, 3200, 1600, 1681));
    send_quad(mk(1600, 1600, 1680, 1600, 3200, 3200, 1600, 3200));
    send_quad(mk(1600, 1600, 3200, 1600, 3200, 1680, 1600, 3200));
    send_quad(mk(1600, 1600, 3200, 1600, 1680, 3200, 1600, 3200));
    send_quad(mk(3200, 1600, 1600, 1600, 3200, 3200, 1600, 3200));
    // all outside, and corners sitting on the margin edges
    send_quad(mk(-16000, -16000, -8000, -16000, -8000, -8000, -16000, -8000));
    send_quad(mk(-480, -320, 6400, -16000, 6400, 40000, -16000, 40000));
    send_quad(mk(-481, -320, 6400, -16000, 6400, 40000, -16000, 40000));
    send_quad(mk(-480, -321, 6400, -16000, 6400, 40000, -16000, 40000));
    send_quad(mk(-16000, -16000, 20000, -16000, 10720, 8000, -16000, 20000));
    send_quad(mk(-16000, -16000, 20000, -16000, 10721, 8000, -16000, 20000));
    send_quad(mk(-16000, -16000, 20000, -16000, 10720, 8001, -16000, 20000));
    // side of exactly 20 and just below
    send_quad(mk(1600, 1600, 1920, 1600, 1920, 1920, 1600, 1920));
    send_quad(mk(1600, 1600, 1919, 1600, 1919, 1919, 1600, 1919));
    // ratio of exactly 7 and just above
    send_quad(mk(1600, 1600, 3840, 1600, 3840, 1920, 1600, 1920));
    send_quad(mk(1600, 1600, 3841, 1600, 3841, 1920, 1600, 1920));
    // skewed parallelogram just under and just over 30 degrees
    send_quad(mk(2600, 1600, 4600, 1600, 3600, 2177, 1600, 2177));
    send_quad(mk(2600, 1600, 4600, 1600, 3600, 2178, 1600, 2178));
    // coordinate extremes
    send_quad(mk(-524288, -524288, -524288, -524288, -524288, -524288, -524288, -524288));
    send_quad(mk(524287, 524287, 524287, 524287, 524287, 524287, 524287, 524287));
    send_quad(mk(-524288, -524288, 524287, -524288, 524287, 524287, -524288, 524287));
    send_quad(mk(0, 0, 524287, -524288, 524287, 524287, -524288, 524287));
  endtask

  initial begin
    int ph_h[5];
    int ph_w[5];
    rst       = 1'b1;
    cfg_wen   = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    corner0_x = '0; corner0_y = '0; corner1_x = '0; corner1_y = '0;
    corner2_x = '0; corner2_y = '0; corner3_x = '0; corner3_y = '0;
    ph_h = '{4095, 1, 0, 0, int'(qcpc_pkg::IMAGE_HEIGHT_RST)};
    ph_w = '{4095, 1, 4095, 0, int'(qcpc_pkg::IMAGE_WIDTH_RST)};
    ph_h[3] = $urandom_range(4095, 1);
    ph_w[3] = $urandom_range(4095, 1);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    for (int n = 0; n < ITEMS_PER_PHASE; n++) send_quad(random_quad());

    for (int p = 0; p < 5; p++) begin
      settle();
      write_reg(qcpc_pkg::REG_IMAGE_HEIGHT, ph_h[p]);
      write_reg(qcpc_pkg::REG_IMAGE_WIDTH, ph_w[p]);
      // first phase runs back to back on both sides
      steady = (p == 0);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (p == 1 && n == ITEMS_PER_PHASE / 2) settle();
        send_quad(random_quad());
      end
    end
    steady = 1'b0;
    settle();

    if (sb.n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
